// File: src/spqt_pkg.sv
`default_nettype none

package spqt_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int MAX_SEGMENTS = 16;

	localparam int PRIO_W  = 8;
	localparam int TAG_W   = 16;
	localparam int CNT_W   = 5;
	localparam int ID_W    = 32;
	localparam int SIDX_W  = 4;
	localparam int STAT_W  = 3;
	localparam int FUNC_W  = 2;
	localparam int SENT_W  = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int TOTAL_W = CNT_W;
	localparam int CMP_W   = ((SENT_W > 9) ? SENT_W : 9) + 1;

	// function codes
	localparam logic [FUNC_W-1:0] FN_ENQ = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REL = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_NULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_MARKER = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		C_HOLD,
		C_INSERT,
		C_POP,
		C_ADVANCE,
		C_MARK
	} cell_op_t;

	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [TAG_W-1:0]   tag;
		logic [ID_W-1:0]    id;
		logic [SENT_W-1:0]  sent;
		logic [TOTAL_W-1:0] total;
	} data_t;

	typedef struct packed {
		logic  valid;
		logic  marker;
		data_t data;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t          op;
		logic [PRIO_W-1:0] req_prio;
		data_t             new_data;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: src/spqt_in_if.sv
`default_nettype none

interface spqt_in_if;
	import spqt_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [PRIO_W-1:0]   priority_req;
	logic [TAG_W-1:0]    seg_tag;
	logic [CNT_W-1:0]    seg_count;

	modport source(output valid, func, priority_req, seg_tag, seg_count, input ready);
	modport sink(input valid, func, priority_req, seg_tag, seg_count, output ready);
endinterface

`default_nettype wire

// File: src/spqt_out_if.sv
`default_nettype none

interface spqt_out_if;
	import spqt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [ID_W-1:0]     msg_id;
	logic [TAG_W-1:0]    out_tag;
	logic [SIDX_W-1:0]   seg_index;
	logic                last_segment;

	modport source(output valid, status, msg_id, out_tag, seg_index, last_segment,
		input ready);
	modport sink(input valid, status, msg_id, out_tag, seg_index, last_segment,
		output ready);
endinterface

`default_nettype wire

// File: src/spqt_cell.sv
`default_nettype none

module spqt_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head,
	input  spqt_pkg::cell_ctl_t ctl,
	input  spqt_pkg::entry_t    left,
	input  wire                 left_stay,
	input  spqt_pkg::entry_t    right,
	output spqt_pkg::entry_t    cur,
	output logic                stay
);
	import spqt_pkg::*;

	logic  valid_q;
	logic  marker_q;
	data_t data_q;

	logic  valid_d;
	logic  marker_d;
	data_t data_d;

	assign cur  = '{valid: valid_q, marker: marker_q, data: data_q};
	// entry ranks ahead of (or equal to) the new word and keeps its place
	assign stay = valid_q && !marker_q && (data_q.prio <= ctl.req_prio);

	always_comb begin
		valid_d  = valid_q;
		marker_d = marker_q;
		data_d   = data_q;
		case (ctl.op)
			C_INSERT: begin
				if (!stay) begin
					if (left_stay) begin
						valid_d  = 1'b1;
						marker_d = 1'b0;
						data_d   = ctl.new_data;
					end else begin
						valid_d  = left.valid;
						marker_d = left.marker;
						data_d   = left.data;
					end
				end
			end
			C_POP: begin
				valid_d  = right.valid;
				marker_d = right.marker;
				data_d   = right.data;
			end
			C_ADVANCE: begin
				if (head)
					data_d.sent = data_q.sent + SENT_W'(1);
			end
			C_MARK: begin
				// first free slot
				if (!valid_q && left.valid) begin
					valid_d  = 1'b1;
					marker_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			marker_q <= 1'b0;
		end else begin
			valid_q  <= valid_d;
			marker_q <= marker_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

`default_nettype wire

// File: src/stable_priority_transmit_queue.sv
`default_nettype none

// Channel | Dir | Fields
// req     | in  | func, priority_req, seg_tag, seg_count
// rsp     | out | status, msg_id, out_tag, seg_index, last_segment
//
// One word in, one word out; a request is taken every cycle while the
// output register is empty or being drained.
// The row of cells updates in the accept cycle and the result lands in
// the output register.
// The row of QUEUE_DEPTH cells compares all entries at once, so insert and
// pop each complete in the accept cycle; rsp stalls back-pressure req directly.
// Reset clears all valid bits and the id counter.
module stable_priority_transmit_queue (
	input wire         clk,
	input wire         arst_n,
	spqt_in_if.sink    req,
	spqt_out_if.source rsp
);
	import spqt_pkg::*;

	entry_t                 cell_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] stay_v;
	logic [QUEUE_DEPTH-1:0] vld_v;
	logic [QUEUE_DEPTH-1:0] mrk_v;

	cell_ctl_t ctl;
	entry_t    left_e  [QUEUE_DEPTH];
	entry_t    right_e [QUEUE_DEPTH];
	logic      left_s  [QUEUE_DEPTH];

	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] id_inc;
	logic [ID_W-1:0] id_next;

	logic               out_valid_q;
	status_t            status_q;
	logic [ID_W-1:0]    msg_id_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [SIDX_W-1:0]  seg_index_q;
	logic               last_q;

	status_t            status_d;
	logic [ID_W-1:0]    msg_id_d;
	logic [TAG_W-1:0]   out_tag_d;
	logic [SIDX_W-1:0]  seg_index_d;
	logic               last_d;
	logic               bump_id;

	logic               acc;
	logic               full;
	logic [CNT_W-1:0]   cnt_nz;
	logic [TOTAL_W-1:0] total;
	logic               head_last;

	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = vld_v[QUEUE_DEPTH-1];

	assign id_inc  = id_q + ID_W'(1);
	assign id_next = (id_inc == '0) ? ID_W'(1) : id_inc;

	assign cnt_nz = (req.seg_count == '0) ? CNT_W'(1) : req.seg_count;
	assign total  = (CMP_W'(cnt_nz) > CMP_W'(MAX_SEGMENTS)) ?
		TOTAL_W'(MAX_SEGMENTS) : TOTAL_W'(cnt_nz);

	assign head_last = (CMP_W'(cell_q[0].data.sent) + CMP_W'(1)) >=
		CMP_W'(cell_q[0].data.total);

	// neighbor wiring; the slot ahead of the head acts as an occupied,
	// staying entry
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			vld_v[k] = cell_q[k].valid;
			mrk_v[k] = cell_q[k].marker;
			if (k == 0) begin
				left_e[k] = '{valid: 1'b1, marker: 1'b0, data: '0};
				left_s[k] = 1'b1;
			end else begin
				left_e[k] = cell_q[k-1];
				left_s[k] = stay_v[k-1];
			end
			if (k == QUEUE_DEPTH - 1)
				right_e[k] = '{valid: 1'b0, marker: 1'b0, data: '0};
			else
				right_e[k] = cell_q[k+1];
		end
	end

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			spqt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.head      (g == 0),
				.ctl       (ctl),
				.left      (left_e[g]),
				.left_stay (left_s[g]),
				.right     (right_e[g]),
				.cur       (cell_q[g]),
				.stay      (stay_v[g])
			);
		end
	endgenerate

	always_comb begin
		ctl.op                = C_HOLD;
		ctl.req_prio          = req.priority_req;
		ctl.new_data.prio     = req.priority_req;
		ctl.new_data.tag      = req.seg_tag;
		ctl.new_data.id       = id_next;
		ctl.new_data.sent     = '0;
		ctl.new_data.total    = total;
		status_d    = ST_OK;
		msg_id_d    = '0;
		out_tag_d   = '0;
		seg_index_d = '0;
		last_d      = 1'b0;
		bump_id     = 1'b0;
		case (req.func)
			FN_ENQ: begin
				if (req.seg_tag == '0) begin
					status_d = ST_NULL;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op   = C_INSERT;
					msg_id_d = id_next;
					bump_id  = 1'b1;
				end
			end
			FN_DEQ: begin
				if (!cell_q[0].valid) begin
					status_d = ST_EMPTY;
				end else if (cell_q[0].marker) begin
					status_d = ST_MARKER;
					ctl.op   = C_POP;
				end else begin
					msg_id_d    = cell_q[0].data.id;
					out_tag_d   = cell_q[0].data.tag;
					seg_index_d = SIDX_W'(cell_q[0].data.sent);
					last_d      = head_last;
					ctl.op      = head_last ? C_POP : C_ADVANCE;
				end
			end
			FN_REL: begin
				if (full)
					status_d = ST_FULL;
				else
					ctl.op = C_MARK;
			end
			default: begin
			end
		endcase
		if (!acc) begin
			ctl.op  = C_HOLD;
			bump_id = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (bump_id)
				id_q <= id_next;
			if (acc)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= status_d;
			msg_id_q    <= msg_id_d;
			out_tag_q   <= out_tag_d;
			seg_index_q <= seg_index_d;
			last_q      <= last_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.msg_id       = msg_id_q;
	assign rsp.out_tag      = out_tag_q;
	assign rsp.seg_index    = seg_index_q;
	assign rsp.last_segment = last_q;

`ifndef SYNTHESIS
	// occupied cells form a prefix of the row
	a_no_hole: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_v >> 1) & ~vld_v) == '0)
		else $error("gap in occupied cells");

	// markers sit behind every message
	a_marker_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(mrk_v & ~(mrk_v >> 1) & (vld_v >> 1)) == '0)
		else $error("message queued behind a release marker");

	// a successful enqueue never hands out id 0
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && bump_id |=> rsp.valid && rsp.msg_id != '0)
		else $error("enqueue produced id 0");

	// every accepted word shows up at the output next cycle
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp.valid)
		else $error("accepted word lost");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_stable_priority_transmit_queue.sv
`default_nettype none

module tb_stable_priority_transmit_queue;
	import spqt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 80;
	localparam int RANDOM_WORDS = 400;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
		logic [CNT_W-1:0]  count;
	} req_word_t;

	typedef struct {
		status_t           status;
		logic [ID_W-1:0]   msg_id;
		logic [TAG_W-1:0]  out_tag;
		logic [SIDX_W-1:0] seg_index;
		logic              last_segment;
	} rsp_word_t;

	typedef struct {
		bit              marker;
		bit [PRIO_W-1:0] prio;
		bit [TAG_W-1:0]  tag;
		bit [ID_W-1:0]   id;
		int              sent;
		int              total;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n;

	spqt_in_if  req_ch ();
	spqt_out_if rsp_ch ();

	stable_priority_transmit_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	req_word_t request_backlog[$];
	rsp_word_t pending_responses[$];
	slot_t     shadow_slots[$];
	bit [ID_W-1:0] shadow_id_ctr;

	int  mismatches;
	int  results_seen;
	int  cycles;
	bit  req_taken;

	// shadow of the sorted queue; returns the response for one request word
	function automatic rsp_word_t predict_queue_response(req_word_t w);
		rsp_word_t o;
		slot_t s;
		int pos;
		int cnt;
		o.status = ST_OK;
		o.msg_id = '0;
		o.out_tag = '0;
		o.seg_index = '0;
		o.last_segment = 1'b0;
		case (w.func)
			FN_ENQ: begin
				if (w.tag == '0) begin
					o.status = ST_NULL;
				end else if (shadow_slots.size() >= QUEUE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					cnt = int'(w.count);
					if (cnt == 0) cnt = 1;
					if (cnt > MAX_SEGMENTS) cnt = MAX_SEGMENTS;
					shadow_id_ctr++;
					if (shadow_id_ctr == '0) shadow_id_ctr++;
					pos = 0;
					while (pos < shadow_slots.size() && !shadow_slots[pos].marker &&
						shadow_slots[pos].prio <= w.prio)
						pos++;
					s.marker = 1'b0;
					s.prio = w.prio;
					s.tag = w.tag;
					s.id = shadow_id_ctr;
					s.sent = 0;
					s.total = cnt;
					shadow_slots.insert(pos, s);
					o.msg_id = shadow_id_ctr;
				end
			end
			FN_DEQ: begin
				if (shadow_slots.size() == 0) begin
					o.status = ST_EMPTY;
				end else if (shadow_slots[0].marker) begin
					o.status = ST_MARKER;
					shadow_slots.delete(0);
				end else begin
					o.msg_id = shadow_slots[0].id;
					o.out_tag = shadow_slots[0].tag;
					o.seg_index = shadow_slots[0].sent[SIDX_W-1:0];
					if (shadow_slots[0].sent + 1 >= shadow_slots[0].total) begin
						o.last_segment = 1'b1;
						shadow_slots.delete(0);
					end else begin
						shadow_slots[0].sent = shadow_slots[0].sent + 1;
					end
				end
			end
			FN_REL: begin
				if (shadow_slots.size() >= QUEUE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					s.marker = 1'b1;
					s.prio = '0;
					s.tag = '0;
					s.id = '0;
					s.sent = 0;
					s.total = 0;
					shadow_slots.insert(shadow_slots.size(), s);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// mostly short gaps, a few long ones; none while quiet
	function automatic int idle_len(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic add_word(logic [FUNC_W-1:0] f, logic [PRIO_W-1:0] p,
		logic [TAG_W-1:0] t, logic [CNT_W-1:0] c);
		req_word_t w;
		w.func = f;
		w.prio = p;
		w.tag = t;
		w.count = c;
		request_backlog.insert(request_backlog.size(), w);
	endtask

	// sender
	int  send_gap;
	bit  send_quiet;
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap--;
			end else if (request_backlog.size() > 0) begin
				req_word_t w;
				w = request_backlog[0];
				request_backlog.delete(0);
				req_ch.valid <= 1'b1;
				req_ch.func <= w.func;
				req_ch.priority_req <= w.prio;
				req_ch.seg_tag <= w.tag;
				req_ch.seg_count <= w.count;
				if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
				send_gap = idle_len(send_quiet);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	int  recv_stall;
	bit  recv_quiet;
	bit  long_hold_done;
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				rsp_ch.ready <= 1'b0;
				recv_stall--;
			end else if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				recv_stall = LONG_HOLD - 1;
			end else begin
				int n;
				if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
				n = idle_len(recv_quiet);
				if (n == 0) begin
					rsp_ch.ready <= 1'b1;
				end else begin
					rsp_ch.ready <= 1'b0;
					recv_stall = n - 1;
				end
			end
		end
	end

	// monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		req_word_t w;
		rsp_word_t exp_w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			req_taken = req_ch.valid && req_ch.ready;
			if (req_taken) begin
				w.func = req_ch.func;
				w.prio = req_ch.priority_req;
				w.tag = req_ch.seg_tag;
				w.count = req_ch.seg_count;
				pending_responses.insert(pending_responses.size(),
					predict_queue_response(w));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (pending_responses.size() == 0) begin
					$error("response word with nothing expected");
					mismatches++;
				end else begin
					exp_w = pending_responses[0];
					pending_responses.delete(0);
					if (rsp_ch.status !== exp_w.status) begin
						$error("status: expected %0d, got %0d", exp_w.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.msg_id !== exp_w.msg_id) begin
						$error("msg_id: expected %0h, got %0h", exp_w.msg_id, rsp_ch.msg_id);
						mismatches++;
					end
					if (rsp_ch.out_tag !== exp_w.out_tag) begin
						$error("out_tag: expected %0h, got %0h", exp_w.out_tag, rsp_ch.out_tag);
						mismatches++;
					end
					if (rsp_ch.seg_index !== exp_w.seg_index) begin
						$error("seg_index: expected %0d, got %0d", exp_w.seg_index,
							rsp_ch.seg_index);
						mismatches++;
					end
					if (rsp_ch.last_segment !== exp_w.last_segment) begin
						$error("last_segment: expected %0b, got %0b", exp_w.last_segment,
							rsp_ch.last_segment);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int r;
		int k;
		logic [FUNC_W-1:0] f;
		logic [PRIO_W-1:0] p;
		logic [TAG_W-1:0] t;
		logic [CNT_W-1:0] c;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_ENQ;
		req_ch.priority_req = '0;
		req_ch.seg_tag = '0;
		req_ch.seg_count = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		results_seen = 0;
		cycles = 0;
		req_taken = 1'b0;
		send_gap = 0;
		send_quiet = 1'b0;
		recv_stall = 0;
		recv_quiet = 1'b0;
		long_hold_done = 1'b0;
		shadow_id_ctr = '0;

		// directed: empty, null tag, unused code, clamped counts, marker, ties, full
		add_word(FN_DEQ, 8'd0, 16'd0, 5'd0);
		add_word(FN_ENQ, 8'd5, 16'd0, 5'd1);
		add_word(FN_NONE, 8'hFF, 16'hFFFF, 5'h1F);
		add_word(FN_ENQ, 8'hFF, 16'hFFFF, 5'd0);
		add_word(FN_REL, 8'd0, 16'd0, 5'd0);
		add_word(FN_ENQ, 8'd0, 16'h0001, 5'd31);
		add_word(FN_ENQ, 8'd0, 16'h0002, 5'd16);
		for (k = 0; k < 12; k++)
			add_word(FN_ENQ, 8'd7, 16'h0100 + TAG_W'(k), 5'd1 + k[4:0]);
		add_word(FN_ENQ, 8'd0, 16'hAAAA, 5'd2);
		add_word(FN_REL, 8'd0, 16'd0, 5'd0);
		for (k = 0; k < 4; k++)
			add_word(FN_DEQ, 8'd0, 16'd0, 5'd0);

		// random: alternating fill-biased and drain-biased stretches
		for (k = 0; k < RANDOM_WORDS; k++) begin
			r = $urandom_range(0, 99);
			if (((k / 40) % 2) == 0)
				f = (r < 50) ? FN_ENQ : (r < 91) ? FN_DEQ : (r < 97) ? FN_REL : FN_NONE;
			else
				f = (r < 15) ? FN_ENQ : (r < 95) ? FN_DEQ : (r < 98) ? FN_REL : FN_NONE;
			p = ($urandom_range(0, 99) < 60) ? PRIO_W'($urandom_range(0, 7)) :
				PRIO_W'($urandom_range(0, 255));
			t = ($urandom_range(0, 99) < 4) ? 16'd0 : TAG_W'($urandom_range(1, 65535));
			r = $urandom_range(0, 99);
			if (r < 70) c = CNT_W'($urandom_range(1, 2));
			else if (r < 90) c = CNT_W'($urandom_range(3, 6));
			else if (r < 97) c = CNT_W'($urandom_range(7, 16));
			else c = CNT_W'($urandom_range(0, 31));
			add_word(f, p, t, c);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (request_backlog.size() == 0 && !req_ch.valid);
		wait (pending_responses.size() == 0);
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
